FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the page buffer policy RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: sv/lpb_pkg.sv
// ----------------------------------------------------------------------------
// lpb_pkg
// Types and fixed constants of the LRU page buffer policy.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpb_pkg;

   localparam int CAP_BITS       = 7;
   localparam logic [CAP_BITS-1:0] CAP_RESET = 7'd64;
   localparam int SLOT_BITS      = 6;
   localparam int PAGE_PORT_BITS = 32;
   localparam int CNT_BITS       = 48;
   localparam int IDX_MAX_BITS   = 10;

   typedef struct packed {
      logic                    load;
      logic [IDX_MAX_BITS-1:0] limit;
      logic [IDX_MAX_BITS-1:0] pick;
   } lpb_cell_ctrl_type;

   typedef struct packed {
      logic fire;
      logic hit;
   } lpb_event_type;

endpackage

FILE: sv/lpb_cell.sv
// ----------------------------------------------------------------------------
// lpb_cell
// One recency stack position: holds a page, its slot and a valid flag,
// compares against the looked-up page and takes its upper neighbour's entry
// when the stack shifts through it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpb_cell #(
   parameter int PAGE_BITS = 32,
   parameter int IDX_W     = 6,
   parameter int INDEX     = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [PAGE_BITS-1:0]      lookup_page,
   input  lpb_pkg::lpb_cell_ctrl_type ctrl,
   input  logic [PAGE_BITS-1:0]      left_page,
   input  logic [IDX_W-1:0]          left_slot,
   input  logic                      left_valid,
   output logic [PAGE_BITS-1:0]      page,
   output logic [IDX_W-1:0]          slot,
   output logic                      valid,
   output logic                      match,
   output logic [PAGE_BITS-1:0]      pick_page,
   output logic [IDX_W-1:0]          pick_slot
);

   localparam logic [lpb_pkg::IDX_MAX_BITS-1:0] MY_IDX = lpb_pkg::IDX_MAX_BITS'(INDEX);

   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic [IDX_W-1:0]     slot_ff, slot_in;
   logic                 valid_ff, valid_in;
   logic                 shift;
   logic                 pick;

   always_comb begin
      shift    = ctrl.load && (MY_IDX <= ctrl.limit);
      page_in  = shift ? left_page  : page_ff;
      slot_in  = shift ? left_slot  : slot_ff;
      valid_in = shift ? left_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff <= page_in;
      slot_ff <= slot_in;
   end

   assign pick      = (MY_IDX == ctrl.pick);
   assign match     = valid_ff && (page_ff == lookup_page);
   assign pick_page = pick ? page_ff : '0;
   assign pick_slot = pick ? slot_ff : '0;
   assign page      = page_ff;
   assign slot      = slot_ff;
   assign valid     = valid_ff;

endmodule

FILE: sv/lpb_counters.sv
// ----------------------------------------------------------------------------
// lpb_counters
// Saturating hit and miss totals, advanced once per completed request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpb_counters (
   input  logic                         clock,
   input  logic                         reset,
   input  lpb_pkg::lpb_event_type       ev,
   output logic [lpb_pkg::CNT_BITS-1:0] hit_total,
   output logic [lpb_pkg::CNT_BITS-1:0] miss_total
);

   logic [lpb_pkg::CNT_BITS-1:0] hit_ff, hit_in;
   logic [lpb_pkg::CNT_BITS-1:0] miss_ff, miss_in;

   always_comb begin
      hit_in  = hit_ff;
      miss_in = miss_ff;
      if (ev.fire && ev.hit && (hit_ff != '1)) begin
         hit_in = hit_ff + 1'b1;
      end
      if (ev.fire && !ev.hit && (miss_ff != '1)) begin
         miss_in = miss_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff  <= '0;
         miss_ff <= '0;
      end else begin
         hit_ff  <= hit_in;
         miss_ff <= miss_in;
      end
   end

   assign hit_total  = hit_ff;
   assign miss_total = miss_ff;

endmodule

FILE: sv/lru_page_buffer_policy.sv
// ----------------------------------------------------------------------------
// lru_page_buffer_policy
// Fully associative LRU replacement policy built as a recency stack of cells.
//
//   channel  direction  payload
//   req_     in         page_number
//   rsp_     out        hit, slot, evicted, evicted_page, fetch_needed,
//                       hit_total, miss_total
//   csr_     in         capacity
//
// A request steps through accept, parallel compare in every cell, then
// the stack shift and result write. One request is in flight at a time; the
// compare-then-shift through the cell row sets that figure.
// A new request is taken while an earlier result waits on rsp_ready; the
// shift stage holds until the result register is free.
// Reset empties the stack, clears the totals and sets capacity to 64.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lru_page_buffer_policy #(
   parameter int ENTRIES   = 64,
   parameter int PAGE_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [lpb_pkg::PAGE_PORT_BITS-1:0] req_page_number,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_hit,
   output logic [lpb_pkg::SLOT_BITS-1:0]      rsp_slot,
   output logic                               rsp_evicted,
   output logic [lpb_pkg::PAGE_PORT_BITS-1:0] rsp_evicted_page,
   output logic                               rsp_fetch_needed,
   output logic [lpb_pkg::CNT_BITS-1:0]       rsp_hit_total,
   output logic [lpb_pkg::CNT_BITS-1:0]       rsp_miss_total,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lpb_pkg::CAP_BITS-1:0]       csr_capacity
);

   localparam int IW   = $clog2(ENTRIES);
   localparam int CW   = $clog2(ENTRIES + 1);
   localparam int CAPW = (CW > lpb_pkg::CAP_BITS) ? CW : lpb_pkg::CAP_BITS;
   localparam int XW   = (IW > lpb_pkg::SLOT_BITS) ? IW : lpb_pkg::SLOT_BITS;
   localparam int XPW  = (PAGE_BITS > lpb_pkg::PAGE_PORT_BITS) ?
                         PAGE_BITS : lpb_pkg::PAGE_PORT_BITS;
   localparam logic [CAPW-1:0] ENTRIES_C = CAPW'(ENTRIES);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LOOK = 2'd1;
   localparam logic [1:0] S_UPD  = 2'd2;

   logic [1:0]                   state_ff, state_in;
   logic [PAGE_BITS-1:0]         page_ff, page_in;
   logic                         found_ff, found_in;
   logic [IW-1:0]                pos_ff, pos_in;
   logic [CW-1:0]                occ_ff, occ_in;
   logic [lpb_pkg::CAP_BITS-1:0] cap_ff, cap_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_hit_ff;
   logic [lpb_pkg::SLOT_BITS-1:0] rsp_slot_ff;
   logic                         rsp_evicted_ff;
   logic [lpb_pkg::PAGE_PORT_BITS-1:0] rsp_evicted_page_ff;
   logic                         rsp_fetch_needed_ff;

   logic [PAGE_BITS-1:0] link_page  [0:ENTRIES];
   logic [IW-1:0]        link_slot  [0:ENTRIES];
   logic                 link_valid [0:ENTRIES];
   logic [ENTRIES-1:0]   match_vec;
   logic [PAGE_BITS-1:0] pick_page_arr [0:ENTRIES-1];
   logic [IW-1:0]        pick_slot_arr [0:ENTRIES-1];

   logic                      req_fire;
   logic                      upd_fire;
   logic [IW-1:0]             pos_c;
   logic [CAPW-1:0]           cap_x;
   logic [CAPW-1:0]           eff_cap;
   logic                      has_room;
   logic                      evict;
   logic [IW-1:0]             last_idx;
   logic [IW-1:0]             limit_idx;
   logic [IW-1:0]             pick_idx;
   logic [IW-1:0]             new_slot;
   logic [PAGE_BITS-1:0]      pick_page;
   logic [IW-1:0]             pick_slot;
   logic [XW-1:0]             slot_x;
   logic [XPW-1:0]            gone_x;
   lpb_pkg::lpb_cell_ctrl_type cell_ctrl;
   lpb_pkg::lpb_event_type     count_ev;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign upd_fire  = (state_ff == S_UPD) && (!rsp_valid_ff || rsp_ready);
   assign csr_ready = 1'b1;

   always_comb begin
      pos_c = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         pos_c = pos_c | (match_vec[i] ? IW'(i) : '0);
      end
   end

   always_comb begin
      cap_x   = CAPW'(cap_ff);
      eff_cap = cap_x;
      if (cap_x == '0) begin
         eff_cap = CAPW'(1);
      end else if (cap_x > ENTRIES_C) begin
         eff_cap = ENTRIES_C;
      end
      has_room  = CAPW'(occ_ff) < eff_cap;
      evict     = !found_ff && !has_room;
      last_idx  = (occ_ff == '0) ? '0 : IW'(occ_ff - 1'b1);
      limit_idx = found_ff ? pos_ff : (has_room ? IW'(occ_ff) : last_idx);
      pick_idx  = found_ff ? pos_ff : last_idx;
   end

   always_comb begin
      pick_page = '0;
      pick_slot = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         pick_page = pick_page | pick_page_arr[i];
         pick_slot = pick_slot | pick_slot_arr[i];
      end
   end

   always_comb begin
      new_slot = (!found_ff && has_room) ? IW'(occ_ff) : pick_slot;
      slot_x   = XW'(new_slot);
      gone_x   = XPW'(pick_page);
   end

   always_comb begin
      cell_ctrl.load  = upd_fire;
      cell_ctrl.limit = lpb_pkg::IDX_MAX_BITS'(limit_idx);
      cell_ctrl.pick  = lpb_pkg::IDX_MAX_BITS'(pick_idx);
      count_ev.fire   = upd_fire;
      count_ev.hit    = found_ff;
   end

   assign link_page[0]  = page_ff;
   assign link_slot[0]  = new_slot;
   assign link_valid[0] = 1'b1;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      lpb_cell #(
         .PAGE_BITS (PAGE_BITS),
         .IDX_W     (IW),
         .INDEX     (g)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .lookup_page (page_ff),
         .ctrl        (cell_ctrl),
         .left_page   (link_page[g]),
         .left_slot   (link_slot[g]),
         .left_valid  (link_valid[g]),
         .page        (link_page[g+1]),
         .slot        (link_slot[g+1]),
         .valid       (link_valid[g+1]),
         .match       (match_vec[g]),
         .pick_page   (pick_page_arr[g]),
         .pick_slot   (pick_slot_arr[g])
      );
   end

   lpb_counters u_counters (
      .clock      (clock),
      .reset      (reset),
      .ev         (count_ev),
      .hit_total  (rsp_hit_total),
      .miss_total (rsp_miss_total)
   );

   always_comb begin
      state_in     = state_ff;
      page_in      = page_ff;
      found_in     = found_ff;
      pos_in       = pos_ff;
      occ_in       = occ_ff;
      cap_in       = cap_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (csr_valid && csr_ready) begin
         cap_in = csr_capacity;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               page_in  = PAGE_BITS'(req_page_number);
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            found_in = |match_vec;
            pos_in   = pos_c;
            state_in = S_UPD;
         end
         S_UPD: begin
            if (upd_fire) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (!found_ff && has_room) begin
                  occ_in = occ_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         occ_ff       <= '0;
         cap_ff       <= lpb_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff  <= page_in;
      found_ff <= found_in;
      pos_ff   <= pos_in;
      if (upd_fire) begin
         rsp_hit_ff          <= found_ff;
         rsp_slot_ff         <= slot_x[lpb_pkg::SLOT_BITS-1:0];
         rsp_evicted_ff      <= evict;
         rsp_evicted_page_ff <= evict ? gone_x[lpb_pkg::PAGE_PORT_BITS-1:0] : '0;
         rsp_fetch_needed_ff <= !found_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_evicted      = rsp_evicted_ff;
   assign rsp_evicted_page = rsp_evicted_page_ff;
   assign rsp_fetch_needed = rsp_fetch_needed_ff;

   `ASSERT_IMPLIES(a_occ_max, clock, reset, 1'b1, CAPW'(occ_ff) <= ENTRIES_C)
   `ASSERT_IMPLIES(a_match_unique, clock, reset, state_ff == S_LOOK, $onehot0(match_vec))
   `ASSERT_IMPLIES(a_evict_is_miss, clock, reset, rsp_valid_ff && rsp_evicted_ff, !rsp_hit_ff && rsp_fetch_needed_ff)
   `ASSERT_NEXT(a_upd_done, clock, reset, upd_fire, rsp_valid_ff && (state_ff == S_IDLE))
   `ASSERT_NEXT(a_occ_hold, clock, reset, !(upd_fire && !found_ff && has_room), occ_ff == $past(occ_ff))

endmodule

FILE: bench/tb_lru_page_buffer_policy.sv
// ----------------------------------------------------------------------------
// tb_lru_page_buffer_policy
// Self-checking bench for the LRU page buffer policy. A directed table opens
// the run (empty buffer, extreme page numbers, capacity zero, above the slot
// count and below occupancy), then phases of random requests drawn mostly from
// a working set sized to the capacity. A recency-stack predictor in the bench
// computes every lookup result. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lru_page_buffer_policy;

   localparam int ENTRIES = 64;
   localparam int POOL_DEPTH = 96;
   localparam logic [lpb_pkg::CNT_BITS-1:0] CNT_TOP = '1;

   typedef enum logic {ROW_REQ, ROW_CAP} row_kind_type;

   typedef struct packed {
      logic                               hit;
      logic [lpb_pkg::SLOT_BITS-1:0]      slot;
      logic                               evicted;
      logic [lpb_pkg::PAGE_PORT_BITS-1:0] evicted_page;
      logic                               fetch_needed;
      logic [lpb_pkg::CNT_BITS-1:0]       hit_total;
      logic [lpb_pkg::CNT_BITS-1:0]       miss_total;
   } lookup_rsp_type;

   typedef struct {
      row_kind_type                       kind;
      logic [lpb_pkg::PAGE_PORT_BITS-1:0] value;
      bit                                 typed;
      lookup_rsp_type                     want;
   } plan_row_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic [lpb_pkg::PAGE_PORT_BITS-1:0] req_page_number = '0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic                               rsp_hit;
   logic [lpb_pkg::SLOT_BITS-1:0]      rsp_slot;
   logic                               rsp_evicted;
   logic [lpb_pkg::PAGE_PORT_BITS-1:0] rsp_evicted_page;
   logic                               rsp_fetch_needed;
   logic [lpb_pkg::CNT_BITS-1:0]       rsp_hit_total;
   logic [lpb_pkg::CNT_BITS-1:0]       rsp_miss_total;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [lpb_pkg::CAP_BITS-1:0]       csr_capacity = '0;

   // recency stack: position 0 is most recent
   logic [lpb_pkg::PAGE_PORT_BITS-1:0] stack_page [ENTRIES];
   logic [lpb_pkg::SLOT_BITS-1:0]      stack_slot [ENTRIES];
   bit                                 stack_valid [ENTRIES];
   int                                 occupied_slots = 0;
   logic [lpb_pkg::CNT_BITS-1:0]       hit_tally = '0;
   logic [lpb_pkg::CNT_BITS-1:0]       miss_tally = '0;
   logic [lpb_pkg::CAP_BITS-1:0]       capacity_reg = lpb_pkg::CAP_RESET;

   lookup_rsp_type                     expected_lookups [$];
   plan_row_type                       opening_rows [$];
   logic [lpb_pkg::PAGE_PORT_BITS-1:0] hot_pages [POOL_DEPTH];
   int phase_caps [11] = '{64, 1, 0, 3, 127, 64, 2, 17, 100, 64, 5};

   int             mismatches = 0;
   bit             send_eager = 1'b0;
   bit             rsp_eager = 1'b0;
   bit             hold_request = 1'b0;
   int             rsp_hold = 0;
   lookup_rsp_type got_rsp;
   lookup_rsp_type want_rsp;

   lru_page_buffer_policy dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_page_number  (req_page_number),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hit          (rsp_hit),
      .rsp_slot         (rsp_slot),
      .rsp_evicted      (rsp_evicted),
      .rsp_evicted_page (rsp_evicted_page),
      .rsp_fetch_needed (rsp_fetch_needed),
      .rsp_hit_total    (rsp_hit_total),
      .rsp_miss_total   (rsp_miss_total),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_capacity     (csr_capacity)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

   function automatic lookup_rsp_type buffer_lookup(
      input logic [lpb_pkg::PAGE_PORT_BITS-1:0] page);
      int                            pos;
      int                            upto;
      int                            eff;
      bit                            found;
      logic [lpb_pkg::SLOT_BITS-1:0] slot;
      lookup_rsp_type                r;
      r = '0;
      found = 1'b0;
      pos = 0;
      eff = (capacity_reg == 0) ? 1 :
            ((capacity_reg > ENTRIES) ? ENTRIES : int'(capacity_reg));
      for (int i = 0; i < ENTRIES; i++) begin
         if (!found && stack_valid[i] && stack_page[i] == page) begin
            pos = i;
            found = 1'b1;
         end
      end
      if (found) begin
         slot = stack_slot[pos];
         upto = pos;
         if (hit_tally != CNT_TOP) hit_tally++;
      end else begin
         if (occupied_slots < eff) begin
            slot = lpb_pkg::SLOT_BITS'(occupied_slots);
            upto = occupied_slots;
            occupied_slots++;
         end else begin
            upto = occupied_slots - 1;
            slot = stack_slot[upto];
            r.evicted = 1'b1;
            r.evicted_page = stack_page[upto];
         end
         if (miss_tally != CNT_TOP) miss_tally++;
      end
      for (int i = upto; i > 0; i--) begin
         stack_page[i] = stack_page[i-1];
         stack_slot[i] = stack_slot[i-1];
         stack_valid[i] = stack_valid[i-1];
      end
      stack_page[0] = page;
      stack_slot[0] = slot;
      stack_valid[0] = 1'b1;
      r.hit = found;
      r.slot = slot;
      r.fetch_needed = !found;
      r.hit_total = hit_tally;
      r.miss_total = miss_tally;
      return r;
   endfunction

   function automatic int idle_len();
      if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatches++;
      $display("mismatch on %s at %0t: got %0h, want %0h", what, $time, got, want);
   endtask

   task automatic add_row(input row_kind_type kind,
                          input logic [lpb_pkg::PAGE_PORT_BITS-1:0] value,
                          input bit typed, input lookup_rsp_type want);
      plan_row_type row;
      row.kind = kind;
      row.value = value;
      row.typed = typed;
      row.want = want;
      opening_rows.insert(opening_rows.size(), row);
   endtask

   task automatic send_page(input logic [lpb_pkg::PAGE_PORT_BITS-1:0] page,
                            input bit typed, input lookup_rsp_type typed_rsp);
      lookup_rsp_type model_rsp;
      int             gap;
      @(negedge clock);
      req_valid <= 1'b1;
      req_page_number <= page;
      do @(posedge clock); while (!req_ready);
      model_rsp = buffer_lookup(page);
      expected_lookups.insert(expected_lookups.size(), typed ? typed_rsp : model_rsp);
      gap = (send_eager || $urandom_range(0, 99) < 50) ? 0 : idle_len();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic write_capacity(input logic [lpb_pkg::CAP_BITS-1:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_lookups.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_capacity <= value;
      do @(posedge clock); while (!csr_ready);
      capacity_reg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // receiver: random stalls, one long hold-off on request
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold = rsp_hold - 1;
      end else if (hold_request) begin
         hold_request = 1'b0;
         rsp_hold = 79;
         rsp_ready <= 1'b0;
      end else if (rsp_eager || $urandom_range(0, 99) < 70) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_hold = idle_len() - 1;
         rsp_ready <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_rsp = '{rsp_hit, rsp_slot, rsp_evicted, rsp_evicted_page, rsp_fetch_needed,
                     rsp_hit_total, rsp_miss_total};
         if (expected_lookups.size() == 0) begin
            report_mismatch("transaction with nothing pending", 64'd1, 64'd0);
         end else begin
            want_rsp = expected_lookups.pop_front();
            if (got_rsp.hit !== want_rsp.hit)
               report_mismatch("hit", got_rsp.hit, want_rsp.hit);
            if (got_rsp.slot !== want_rsp.slot)
               report_mismatch("slot", got_rsp.slot, want_rsp.slot);
            if (got_rsp.evicted !== want_rsp.evicted)
               report_mismatch("evicted", got_rsp.evicted, want_rsp.evicted);
            if (got_rsp.evicted_page !== want_rsp.evicted_page)
               report_mismatch("evicted_page", got_rsp.evicted_page, want_rsp.evicted_page);
            if (got_rsp.fetch_needed !== want_rsp.fetch_needed)
               report_mismatch("fetch_needed", got_rsp.fetch_needed, want_rsp.fetch_needed);
            if (got_rsp.hit_total !== want_rsp.hit_total)
               report_mismatch("hit_total", got_rsp.hit_total, want_rsp.hit_total);
            if (got_rsp.miss_total !== want_rsp.miss_total)
               report_mismatch("miss_total", got_rsp.miss_total, want_rsp.miss_total);
         end
      end
   end

   initial begin : stimulus
      int                                 pool_n;
      int                                 roll;
      int                                 bitpos;
      int                                 cap_eff;
      logic [lpb_pkg::PAGE_PORT_BITS-1:0] page;

      foreach (stack_valid[i]) begin
         stack_valid[i] = 1'b0;
         stack_page[i] = '0;
         stack_slot[i] = '0;
      end
      foreach (hot_pages[i]) hot_pages[i] = $urandom;

      // empty buffer, extreme pages, then capacity zero, clamp and below occupancy
      add_row(ROW_REQ, 32'h0000_0000, 1'b1,
              {1'b0, 6'd0, 1'b0, 32'h0, 1'b1, 48'd0, 48'd1});
      add_row(ROW_REQ, 32'hFFFF_FFFF, 1'b1,
              {1'b0, 6'd1, 1'b0, 32'h0, 1'b1, 48'd0, 48'd2});
      add_row(ROW_REQ, 32'h0000_0000, 1'b1,
              {1'b1, 6'd0, 1'b0, 32'h0, 1'b0, 48'd1, 48'd2});
      add_row(ROW_REQ, 32'hFFFF_FFFF, 1'b1,
              {1'b1, 6'd1, 1'b0, 32'h0, 1'b0, 48'd2, 48'd2});
      add_row(ROW_CAP, 32'd0, 1'b0, '0);
      add_row(ROW_REQ, 32'h0000_0005, 1'b1,
              {1'b0, 6'd0, 1'b1, 32'h0, 1'b1, 48'd2, 48'd3});
      add_row(ROW_REQ, 32'hA5A5_A5A5, 1'b1,
              {1'b0, 6'd1, 1'b1, 32'hFFFF_FFFF, 1'b1, 48'd2, 48'd4});
      add_row(ROW_REQ, 32'h0000_0005, 1'b1,
              {1'b1, 6'd0, 1'b0, 32'h0, 1'b0, 48'd3, 48'd4});
      add_row(ROW_CAP, 32'd127, 1'b0, '0);
      add_row(ROW_REQ, 32'h5A5A_5A5A, 1'b1,
              {1'b0, 6'd2, 1'b0, 32'h0, 1'b1, 48'd3, 48'd5});
      add_row(ROW_CAP, 32'd1, 1'b0, '0);
      add_row(ROW_REQ, 32'h0000_0001, 1'b1,
              {1'b0, 6'd1, 1'b1, 32'hA5A5_A5A5, 1'b1, 48'd3, 48'd6});
      add_row(ROW_REQ, 32'h8000_0000, 1'b1,
              {1'b0, 6'd0, 1'b1, 32'h5, 1'b1, 48'd3, 48'd7});
      add_row(ROW_REQ, 32'h5A5A_5A5A, 1'b1,
              {1'b1, 6'd2, 1'b0, 32'h0, 1'b0, 48'd4, 48'd7});
      add_row(ROW_REQ, 32'h0000_0005, 1'b0, '0);
      add_row(ROW_CAP, 32'd2, 1'b0, '0);
      add_row(ROW_REQ, 32'h0000_FFFF, 1'b0, '0);
      add_row(ROW_CAP, 32'd64, 1'b0, '0);
      add_row(ROW_REQ, 32'h1234_5678, 1'b0, '0);
      add_row(ROW_REQ, 32'hFFFF_0000, 1'b0, '0);
      add_row(ROW_REQ, 32'h5A5A_5A5A, 1'b0, '0);
      add_row(ROW_REQ, 32'h8000_0000, 1'b0, '0);
      add_row(ROW_REQ, 32'h7FFF_FFFF, 1'b0, '0);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (opening_rows[r]) begin
         if (opening_rows[r].kind == ROW_CAP)
            write_capacity(opening_rows[r].value[lpb_pkg::CAP_BITS-1:0]);
         else
            send_page(opening_rows[r].value, opening_rows[r].typed, opening_rows[r].want);
      end

      foreach (phase_caps[p]) begin
         write_capacity(lpb_pkg::CAP_BITS'(phase_caps[p]));
         cap_eff = (phase_caps[p] == 0) ? 1 :
                   ((phase_caps[p] > ENTRIES) ? ENTRIES : phase_caps[p]);
         pool_n = cap_eff + $urandom_range(1, cap_eff / 2 + 3);
         if (pool_n > POOL_DEPTH) pool_n = POOL_DEPTH;
         for (int k = 0; k < pool_n / 4 + 1; k++)
            hot_pages[$urandom_range(0, POOL_DEPTH - 1)] = $urandom;
         send_eager = (p == 0 || p == 3 || p == 7);
         rsp_eager = (p == 3 || p == 7);
         if (p == 0) hold_request = 1'b1;
         for (int n = 0; n < 110; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
               page = hot_pages[$urandom_range(0, pool_n - 1)];
            end else if (roll < 85) begin
               page = $urandom;
            end else begin
               bitpos = $urandom_range(0, 31);
               case ($urandom_range(0, 3))
                  0: begin
                     page = '0;
                  end
                  1: begin
                     page = '1;
                  end
                  2: begin
                     page = 32'd1 << bitpos;
                  end
                  default: begin
                     page = ~(32'd1 << bitpos);
                  end
               endcase
            end
            send_page(page, 1'b0, '0);
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_lookups.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+sv
sv/lpb_pkg.sv
sv/lpb_cell.sv
sv/lpb_counters.sv
sv/lru_page_buffer_policy.sv
bench/tb_lru_page_buffer_policy.sv
